// ===== rtl/mwa_pkg.sv =====
// shared opcodes, size helpers and controller/datapath link types for the multi-width alu
`timescale 1ns / 1ps

package mwa_pkg;

	// operation codes
	localparam logic [5:0] OP_ADD = 6'd1;
	localparam logic [5:0] OP_SUB = 6'd2;
	localparam logic [5:0] OP_MUL = 6'd3;
	localparam logic [5:0] OP_DIV = 6'd4;
	localparam logic [5:0] OP_MOV = 6'd5;
	localparam logic [5:0] OP_AND = 6'd11;
	localparam logic [5:0] OP_OR  = 6'd12;
	localparam logic [5:0] OP_XOR = 6'd13;
	localparam logic [5:0] OP_NOT = 6'd14;
	localparam logic [5:0] OP_SHL = 6'd15;
	localparam logic [5:0] OP_SHR = 6'd16;
	localparam logic [5:0] OP_SEI = 6'd17;
	localparam logic [5:0] OP_SDI = 6'd18;
	localparam logic [5:0] OP_CMP = 6'd20;
	localparam logic [5:0] OP_REM = 6'd21;

	// operand size codes
	localparam logic [1:0] SZ_8  = 2'd0;
	localparam logic [1:0] SZ_16 = 2'd1;
	localparam logic [1:0] SZ_32 = 2'd2;
	localparam logic [1:0] SZ_64 = 2'd3;

	// multiplier runs four 32x32 partial products, then one last accumulate
	localparam logic [2:0] MUL_LAST = 3'd4;
	// divider retires one quotient bit per cycle
	localparam logic [5:0] DIV_LAST = 6'd63;

	// controller to datapath
	typedef struct packed {
		logic       take;
		logic       mul_step;
		logic [2:0] mul_idx;
		logic       div_step;
		logic       commit;
	} mwa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;
		logic is_mul;
		logic is_div;
		logic div_zero;
		logic out_free;
	} mwa_stat_t;

	// low-bit mask for an operand size
	function automatic logic [63:0] size_mask(input logic [1:0] sz);
		logic [63:0] m;
		unique case (sz)
			SZ_8:    m = 64'h0000_0000_0000_00FF;
			SZ_16:   m = 64'h0000_0000_0000_FFFF;
			SZ_32:   m = 64'h0000_0000_FFFF_FFFF;
			SZ_64:   m = 64'hFFFF_FFFF_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	// operand width in bits for a size code
	function automatic logic [6:0] size_bits(input logic [1:0] sz);
		logic [6:0] b;
		unique case (sz)
			SZ_8:    b = 7'd8;
			SZ_16:   b = 7'd16;
			SZ_32:   b = 7'd32;
			SZ_64:   b = 7'd64;
			default: b = 7'd64;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/mwa_if.sv =====
// valid/ready channel interfaces for the alu operation and result streams
`timescale 1ns / 1ps

interface mwa_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  opcode;
	logic [1:0]  operand_size;
	logic [63:0] dst_value;
	logic [63:0] src_value;

	modport source (output valid, output opcode, output operand_size,
		output dst_value, output src_value, input ready);
	modport sink (input valid, input opcode, input operand_size,
		input dst_value, input src_value, output ready);
endinterface

interface mwa_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_value;
	logic        write_result;
	logic        carry_flag;
	logic        zero_flag;
	logic        greater_flag;
	logic        lesser_flag;
	logic        interrupt_enable;
	logic        divide_by_zero;

	modport source (output valid, output result_value, output write_result,
		output carry_flag, output zero_flag, output greater_flag, output lesser_flag,
		output interrupt_enable, output divide_by_zero, input ready);
	modport sink (input valid, input result_value, input write_result,
		input carry_flag, input zero_flag, input greater_flag, input lesser_flag,
		input interrupt_enable, input divide_by_zero, output ready);
endinterface

// ===== rtl/multi_width_alu_with_flags.sv =====
// top level of the multi-width alu with carry, zero, greater, lesser and interrupt flags
//
// usage:
//   in_ch carries one operation per transfer: opcode, operand_size (8/16/32/64 bits),
//   dst_value and src_value. out_ch returns one result per operation: the sized result,
//   write_result, the five flags as they stand after the operation, and divide_by_zero.
//   one operation is in flight at a time; in_ch.ready is high only while the unit is idle,
//   so a new operation can be taken while the previous result still waits on out_ch.
// sequence from accept to result valid:
//   every op passes a decode state and then a finish state; mul adds a multiply state
//   between them (four 32x32 partial products through one registered multiplier plus
//   accumulate), div and rem with a nonzero divisor add a divide state (restoring divider,
//   one quotient bit per cycle over all 64 bits); a zero divisor goes straight to finish.
//   the unit returns to idle after each commit before it takes the next operation.
// reset: arst_n clears the flags, the controller and the result valid bit; no clearing pass.
// stall: a finished result waits in the output register while out_ch.ready is low; the
//   next finished operation holds in the controller until that register frees up.
`timescale 1ns / 1ps

module multi_width_alu_with_flags import mwa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mwa_in_if.sink    in_ch,
	mwa_out_if.source out_ch
);

	mwa_cmd_t  cmd;
	mwa_stat_t stat;

	mwa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	mwa_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== rtl/mwa_datapath.sv =====
// alu datapath: operand registers, shared mul/div accumulator, flags and result register
`timescale 1ns / 1ps

module mwa_datapath import mwa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mwa_in_if.sink    in_ch,
	mwa_out_if.source out_ch,
	input  mwa_cmd_t  cmd,
	output mwa_stat_t stat
);

	logic [5:0]   op_q;
	logic [1:0]   sz_q;
	logic [63:0]  d_q;
	logic [63:0]  s_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;

	logic carry_q, zero_q, greater_q, lesser_q, ie_q;

	logic        out_valid_q;
	logic [63:0] res_q;
	logic        wr_q;
	logic        dz_q;

	logic [63:0] in_mask;
	logic        in_is_div;
	logic [63:0] m;
	logic [6:0]  bits;
	logic [64:0] sum;
	logic        div_zero;
	logic        sh_big;

	logic [31:0]  mul_a, mul_b;
	logic [2:0]   prev_idx;
	logic [127:0] addend;

	logic [64:0] r_sh;
	logic        r_ge;
	logic [64:0] r_new;

	logic [63:0] n_res;
	logic        n_wr, n_cy, n_z, n_g, n_l, n_ie, n_dz;

	// input handshake
	assign in_ch.ready = cmd.take;
	assign in_mask     = size_mask(in_ch.operand_size);
	assign in_is_div   = (in_ch.opcode == OP_DIV) || (in_ch.opcode == OP_REM);

	// status toward the controller
	assign m        = size_mask(sz_q);
	assign bits     = size_bits(sz_q);
	assign div_zero = (s_q == 64'd0);
	assign stat.in_valid = in_ch.valid;
	assign stat.is_mul   = (op_q == OP_MUL);
	assign stat.is_div   = (op_q == OP_DIV) || (op_q == OP_REM);
	assign stat.div_zero = div_zero;
	assign stat.out_free = !out_valid_q || out_ch.ready;

	// partial product operand select
	assign mul_a    = cmd.mul_idx[1] ? d_q[63:32] : d_q[31:0];
	assign mul_b    = cmd.mul_idx[0] ? s_q[63:32] : s_q[31:0];
	assign prev_idx = cmd.mul_idx - 3'd1;

	// align the previous partial product for accumulation
	always_comb begin
		unique case (prev_idx)
			3'd0:    addend = {64'd0, pp_q};
			3'd1:    addend = {32'd0, pp_q, 32'd0};
			3'd2:    addend = {32'd0, pp_q, 32'd0};
			3'd3:    addend = {pp_q, 64'd0};
			default: addend = 128'd0;
		endcase
	end

	// restoring divide step: remainder in the upper half, quotient shifts in below
	assign r_sh  = {acc_q[127:64], acc_q[63]};
	assign r_ge  = (r_sh >= {1'b0, s_q});
	assign r_new = r_ge ? (r_sh - {1'b0, s_q}) : r_sh;

	// operand, multiply and divide registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && cmd.take) begin
			op_q  <= in_ch.opcode;
			sz_q  <= in_ch.operand_size;
			d_q   <= in_ch.dst_value & in_mask;
			s_q   <= in_ch.src_value & in_mask;
			acc_q <= in_is_div ? {64'd0, in_ch.dst_value & in_mask} : 128'd0;
		end else if (cmd.mul_step) begin
			if (cmd.mul_idx != MUL_LAST)
				pp_q <= mul_a * mul_b;
			if (cmd.mul_idx != 3'd0)
				acc_q <= acc_q + addend;
		end else if (cmd.div_step) begin
			acc_q <= {r_new[63:0], acc_q[62:0], r_ge};
		end
	end

	// result and flag evaluation
	assign sum    = {1'b0, d_q} + {1'b0, s_q};
	assign sh_big = (s_q >= {57'd0, bits});

	always_comb begin
		n_res = 64'd0;
		n_wr  = 1'b0;
		n_cy  = carry_q;
		n_z   = zero_q;
		n_g   = greater_q;
		n_l   = lesser_q;
		n_ie  = ie_q;
		n_dz  = 1'b0;
		unique case (op_q)
			OP_ADD: begin
				n_res = sum[63:0] & m;
				n_cy  = sum[bits];
				n_wr  = 1'b1;
			end
			OP_SUB: begin
				n_res = (d_q - s_q) & m;
				n_cy  = (d_q < s_q);
				n_wr  = 1'b1;
			end
			OP_MUL: begin
				n_res = acc_q[63:0] & m;
				n_cy  = |(acc_q & ~{64'd0, m});
				n_wr  = 1'b1;
			end
			OP_DIV: begin
				n_res = div_zero ? m : acc_q[63:0];
				n_cy  = 1'b0;
				n_dz  = div_zero;
				n_wr  = 1'b1;
			end
			OP_REM: begin
				n_res = div_zero ? d_q : acc_q[127:64];
				n_cy  = 1'b0;
				n_dz  = div_zero;
				n_wr  = 1'b1;
			end
			OP_MOV: begin
				n_res = s_q;
				n_wr  = 1'b1;
			end
			OP_AND: begin
				n_res = d_q & s_q;
				n_wr  = 1'b1;
			end
			OP_OR: begin
				n_res = d_q | s_q;
				n_wr  = 1'b1;
			end
			OP_XOR: begin
				n_res = d_q ^ s_q;
				n_wr  = 1'b1;
			end
			OP_NOT: begin
				n_res = ~d_q & m;
				n_wr  = 1'b1;
			end
			OP_SHL: begin
				n_res = sh_big ? 64'd0 : ((d_q << s_q[5:0]) & m);
				n_wr  = 1'b1;
			end
			OP_SHR: begin
				n_res = sh_big ? 64'd0 : (d_q >> s_q[5:0]);
				n_wr  = 1'b1;
			end
			OP_SEI: n_ie = 1'b1;
			OP_SDI: n_ie = 1'b0;
			OP_CMP: begin
				n_g = (d_q > s_q);
				n_l = (d_q < s_q);
				n_z = (d_q == s_q);
			end
			default: n_wr = 1'b0;
		endcase
		// arithmetic ops set zero from the sized result
		if (op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL ||
			op_q == OP_DIV || op_q == OP_REM)
			n_z = (n_res == 64'd0);
	end

	// flag state, updated when a result is committed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q   <= 1'b0;
			zero_q    <= 1'b0;
			greater_q <= 1'b0;
			lesser_q  <= 1'b0;
			ie_q      <= 1'b0;
		end else if (cmd.commit) begin
			carry_q   <= n_cy;
			zero_q    <= n_z;
			greater_q <= n_g;
			lesser_q  <= n_l;
			ie_q      <= n_ie;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.commit)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= n_res;
			wr_q  <= n_wr;
			dz_q  <= n_dz;
		end
	end

	// result channel; flags hold until the next commit
	assign out_ch.valid            = out_valid_q;
	assign out_ch.result_value     = res_q;
	assign out_ch.write_result     = wr_q;
	assign out_ch.divide_by_zero   = dz_q;
	assign out_ch.carry_flag       = carry_q;
	assign out_ch.zero_flag        = zero_q;
	assign out_ch.greater_flag     = greater_q;
	assign out_ch.lesser_flag      = lesser_q;
	assign out_ch.interrupt_enable = ie_q;

	// checks
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed result not presented");

	a_dz_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dz_q) |-> wr_q)
		else $error("divide by zero without result write");

	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !wr_q) |-> (res_q == 64'd0))
		else $error("non-writing op has nonzero result");

endmodule

// ===== rtl/mwa_ctrl.sv =====
// alu controller: sequences accept, multiply and divide steps, and result commit
`timescale 1ns / 1ps

module mwa_ctrl import mwa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  mwa_stat_t stat,
	output mwa_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_FIN    = 3'd4;

	logic [2:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd.take     = 1'b0;
		cmd.mul_step = 1'b0;
		cmd.div_step = 1'b0;
		cmd.commit   = 1'b0;
		cmd.mul_idx  = cnt_q[2:0];
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = 1'b1;
				if (stat.in_valid)
					state_d = ST_DECODE;
			end
			ST_DECODE: begin
				cnt_d = 6'd0;
				priority if (stat.is_mul)
					state_d = ST_MUL;
				else if (stat.is_div && !stat.div_zero)
					state_d = ST_DIV;
				else
					state_d = ST_FIN;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q[2:0] == MUL_LAST)
					state_d = ST_FIN;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 6'd1;
				if (cnt_q == DIV_LAST)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 6'd0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// checks
	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && stat.in_valid) |=> (state_q == ST_DECODE))
		else $error("accepted transfer not decoded");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == DIV_LAST) |=> (state_q == ST_FIN))
		else $error("divide did not finish after last step");

	a_mul_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && cnt_q[2:0] == MUL_LAST) |=> (state_q == ST_FIN))
		else $error("multiply did not finish after last step");

endmodule
